@@ design/serial_line_editor_assert.svh @@
// Assertion helpers for the serial line editor.
// SLE_ASSERT is disabled during reset, SLE_ASSERT_ALWAYS is checked at every edge.
`ifndef SERIAL_LINE_EDITOR_ASSERT_SVH
`define SERIAL_LINE_EDITOR_ASSERT_SVH

`ifndef ASSERT_OFF
`define SLE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SLE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SLE_ASSERT(lbl, prop, msg)
`define SLE_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ design/sle_pkg.sv @@
`default_nettype none

package sle_pkg;

  // default store depth
  localparam int SLE_MAX_LINE = 64;

  // field widths
  localparam int CHAR_W = 8;
  localparam int LEN_W  = 6;
  localparam int RIDX_W = 6;
  localparam int KIND_W = 2;
  localparam int LSIZE_W = 7;
  localparam int CFG_W   = 7;

  // input commands
  localparam logic CMD_RX   = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_ECHO = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LINE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  // register indexes
  localparam logic CFG_LINE_SIZE = 1'b0;
  localparam logic CFG_MASK_EN   = 1'b1;

  // register reset values
  localparam logic [LSIZE_W-1:0] LINE_SIZE_RST = 7'd32;
  localparam logic               MASK_EN_RST   = 1'b1;

  // characters
  localparam logic [CHAR_W-1:0] CH_CTRL_Q = 8'h11;
  localparam logic [CHAR_W-1:0] CH_CTRL_S = 8'h13;
  localparam logic [CHAR_W-1:0] CH_DEL    = 8'h7F;
  localparam logic [CHAR_W-1:0] CH_BS     = 8'h08;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_LOW_S  = 8'h73;
  localparam logic [CHAR_W-1:0] CH_LOW_U  = 8'h75;
  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;

  // what result sequence an item produces
  typedef enum logic [2:0] {
    RT_READ,   // stored character
    RT_CR,     // line complete
    RT_ECHO,   // single echo
    RT_LAST,   // echo then backspace
    RT_BSEQ    // backspace, space, backspace
  } rtype_t;

  // item descriptor passed from the edit stage to the output sequencer
  typedef struct packed {
    rtype_t              rtype;
    logic [CHAR_W-1:0]   ch;
    logic [LEN_W-1:0]    len;
  } desc_t;

endpackage

`default_nettype wire

@@ design/sle_intf.sv @@
`default_nettype none

// input channel
interface sle_in_if import sle_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [CHAR_W-1:0] rx_byte;
  logic [RIDX_W-1:0] read_index;

  modport source (output valid, cmd, rx_byte, read_index, input ready);
  modport sink   (input valid, cmd, rx_byte, read_index, output ready);
endinterface

// result channel
interface sle_out_if import sle_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [CHAR_W-1:0] char_value;
  logic [LEN_W-1:0]  line_length;
  logic              last;

  modport source (output valid, kind, char_value, line_length, last, input ready);
  modport sink   (input valid, kind, char_value, line_length, last, output ready);
endinterface

`default_nettype wire

@@ design/sle_ram.sv @@
`default_nettype none

module sle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/sle_ctrl.sv @@
`default_nettype none
`include "serial_line_editor_assert.svh"

module sle_ctrl import sle_pkg::*; #(
  parameter int MAX_LINE = SLE_MAX_LINE
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_wdata,
  input  wire logic              in_fire,
  input  wire logic              in_cmd,
  input  wire logic [CHAR_W-1:0] in_rx_byte,
  input  wire logic [RIDX_W-1:0] in_read_index,
  input  wire logic              out_free,
  output logic                   s1_valid,
  output desc_t                  s1_desc
);

  localparam int PW = $clog2(MAX_LINE);
  localparam int CW = $clog2(MAX_LINE + 1);
  localparam int LW = (CW > LSIZE_W) ? CW : LSIZE_W;

  // configuration
  logic [LSIZE_W-1:0] line_size_r;
  logic               mask_en_r;

  // edit state
  logic [PW-1:0] write_pos_r, write_pos_nxt;
  logic          filled_r, filled_nxt;
  logic          s0_r, s0_nxt;   // store[0] holds 's'
  logic          u1_r, u1_nxt;   // store[1] holds 'u'

  // stage after the store access
  logic  s1_valid_r, s1_valid_nxt;
  desc_t s1_desc_r, s1_desc_nxt;
  logic  s1_zero_r, s1_zero_nxt;

  // store port
  logic              ram_we, ram_re;
  logic [PW-1:0]     ram_waddr, ram_raddr;
  logic [CHAR_W-1:0] ram_wdata, ram_rdata;

  logic [LW-1:0] ls_ext;
  logic [CW-1:0] cap;
  logic [PW-1:0] last_slot, wp;
  logic          go;

  sle_ram #(.WIDTH(CHAR_W), .DEPTH(MAX_LINE)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // clamped capacity and position
  always_comb begin
    ls_ext = LW'(line_size_r);
    if (ls_ext < LW'(3)) begin
      cap = CW'(3);
    end else if (ls_ext > LW'(MAX_LINE)) begin
      cap = CW'(MAX_LINE);
    end else begin
      cap = CW'(ls_ext);
    end
    last_slot = PW'(cap - CW'(2));
    wp = (write_pos_r > last_slot) ? last_slot : write_pos_r;
  end

  // edit decode
  always_comb begin
    write_pos_nxt = write_pos_r;
    filled_nxt    = filled_r;
    ram_we        = 1'b0;
    ram_waddr     = wp;
    ram_wdata     = in_rx_byte;
    ram_re        = 1'b0;
    ram_raddr     = PW'(in_read_index);
    go            = 1'b0;
    s1_zero_nxt   = 1'b0;
    s1_desc_nxt.rtype = RT_ECHO;
    s1_desc_nxt.ch    = in_rx_byte;
    s1_desc_nxt.len   = '0;
    if (in_fire) begin
      if (in_cmd == CMD_READ) begin
        ram_re = 1'b1;
        go     = 1'b1;
        s1_desc_nxt.rtype = RT_READ;
        s1_zero_nxt = (int'(in_read_index) >= MAX_LINE);
      end else begin
        write_pos_nxt = wp;
        case (in_rx_byte)
          CH_CR: begin
            ram_we    = 1'b1;
            ram_wdata = CH_NUL;
            if (wp == last_slot && filled_r) begin
              ram_waddr = PW'(cap - CW'(1));
              s1_desc_nxt.len = LEN_W'(cap - CW'(1));
            end else begin
              s1_desc_nxt.len = LEN_W'(wp);
            end
            write_pos_nxt = '0;
            filled_nxt    = 1'b0;
            go            = 1'b1;
            s1_desc_nxt.rtype = RT_CR;
          end
          CH_BS, CH_DEL: begin
            if (wp != '0) begin
              write_pos_nxt = wp - PW'(1);
              filled_nxt    = 1'b0;
              go            = 1'b1;
              s1_desc_nxt.rtype = RT_BSEQ;
            end
          end
          CH_CTRL_Q, CH_CTRL_S: begin
            // flow control bytes are dropped
          end
          default: begin
            ram_we = 1'b1;
            go     = 1'b1;
            if (wp == last_slot) begin
              filled_nxt = 1'b1;
              s1_desc_nxt.rtype = RT_LAST;
            end else begin
              filled_nxt    = 1'b0;
              write_pos_nxt = wp + PW'(1);
              if (mask_en_r && s0_r && u1_r && wp > PW'(2)) begin
                s1_desc_nxt.ch = CH_STAR;
              end
            end
          end
        endcase
      end
    end
  end

  // shadow of the first two store entries for the prefix check
  always_comb begin
    s0_nxt = s0_r;
    u1_nxt = u1_r;
    if (ram_we && ram_waddr == PW'(0)) begin
      s0_nxt = (ram_wdata == CH_LOW_S);
    end
    if (ram_we && ram_waddr == PW'(1)) begin
      u1_nxt = (ram_wdata == CH_LOW_U);
    end
  end

  assign s1_valid_nxt = go | (s1_valid_r & ~out_free);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_size_r <= LINE_SIZE_RST;
      mask_en_r   <= MASK_EN_RST;
      write_pos_r <= '0;
      filled_r    <= 1'b0;
      s0_r        <= 1'b0;
      u1_r        <= 1'b0;
      s1_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LINE_SIZE: line_size_r <= cfg_wdata[LSIZE_W-1:0];
          CFG_MASK_EN:   mask_en_r   <= cfg_wdata[0];
          default: ;
        endcase
      end
      write_pos_r <= write_pos_nxt;
      filled_r    <= filled_nxt;
      s0_r        <= s0_nxt;
      u1_r        <= u1_nxt;
      s1_valid_r  <= s1_valid_nxt;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (go) begin
      s1_desc_r <= s1_desc_nxt;
      s1_zero_r <= s1_zero_nxt;
    end
  end

  // read data joins the descriptor here
  always_comb begin
    s1_desc = s1_desc_r;
    if (s1_desc_r.rtype == RT_READ) begin
      s1_desc.ch = s1_zero_r ? CH_NUL : ram_rdata;
    end
  end

  assign s1_valid = s1_valid_r;

  `SLE_ASSERT(a_pos_in_range, write_pos_r <= PW'(MAX_LINE - 2), "write position beyond store")
  `SLE_ASSERT(a_s1_hold, s1_valid_r && !out_free |=> s1_valid_r && $stable(s1_desc_r), "stalled item lost")

endmodule

`default_nettype wire

@@ design/sle_out.sv @@
`default_nettype none
`include "serial_line_editor_assert.svh"

module sle_out import sle_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              s1_valid,
  input  wire desc_t             s1_desc,
  output logic                   out_free,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [KIND_W-1:0]      out_kind,
  output logic [CHAR_W-1:0]      out_char,
  output logic [LEN_W-1:0]       out_len,
  output logic                   out_last
);

  logic        out_valid_r;
  logic [1:0]  idx_r;
  desc_t       desc_r;

  // result sequence for the held item
  always_comb begin
    out_kind = KIND_ECHO;
    out_char = desc_r.ch;
    out_len  = '0;
    out_last = 1'b1;
    case (desc_r.rtype)
      RT_READ: begin
        out_kind = KIND_READ;
      end
      RT_CR: begin
        out_kind = KIND_LINE;
        out_char = CH_LF;
        out_len  = desc_r.len;
      end
      RT_ECHO: ;
      RT_LAST: begin
        out_char = (idx_r == 2'd0) ? desc_r.ch : CH_BS;
        out_last = (idx_r == 2'd1);
      end
      RT_BSEQ: begin
        out_char = (idx_r == 2'd1) ? CH_SPACE : CH_BS;
        out_last = (idx_r == 2'd2);
      end
      default: ;
    endcase
  end

  assign out_free  = ~out_valid_r | (out_ready & out_last);
  assign out_valid = out_valid_r;

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else if (out_free) begin
      out_valid_r <= s1_valid;
      idx_r       <= '0;
    end else if (out_ready) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  // held item
  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      desc_r <= s1_desc;
    end
  end

  `SLE_ASSERT(a_stall_hold, out_valid_r && !out_ready |=> out_valid_r && $stable(idx_r), "output stepped while stalled")
  `SLE_ASSERT(a_idx_bound, out_valid_r && desc_r.rtype != RT_BSEQ |-> idx_r <= 2'd1, "result index past sequence end")

endmodule

`default_nettype wire

@@ design/serial_line_editor.sv @@
// Serial line editor: edits received bytes into a line store, echoes them and answers reads.
// An accepted item passes the edit stage register, then the output sequencer register.
// Throughput: one item per cycle while the output is ready and items have one
// result; an item with k results (up to 3, backspace sequence) holds the sequencer.
// Reset (rst_n, synchronous): position, flags and pipeline cleared, line_size 32,
// mask_enable 1; the line store is not cleared.
`default_nettype none

module serial_line_editor import sle_pkg::*; #(
  parameter int MAX_LINE = SLE_MAX_LINE
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  sle_in_if.sink                in_ch,
  sle_out_if.source             out_ch
);

  logic  in_fire;
  logic  s1_valid;
  desc_t s1_desc;
  logic  out_free;

  // take a new item whenever the edit stage is empty or moving on
  assign in_ch.ready = ~s1_valid | out_free;
  assign in_fire     = in_ch.valid & in_ch.ready;

  sle_ctrl #(.MAX_LINE(MAX_LINE)) u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_fire       (in_fire),
    .in_cmd        (in_ch.cmd),
    .in_rx_byte    (in_ch.rx_byte),
    .in_read_index (in_ch.read_index),
    .out_free      (out_free),
    .s1_valid      (s1_valid),
    .s1_desc       (s1_desc)
  );

  sle_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_desc   (s1_desc),
    .out_free  (out_free),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_kind  (out_ch.kind),
    .out_char  (out_ch.char_value),
    .out_len   (out_ch.line_length),
    .out_last  (out_ch.last)
  );

endmodule

`default_nettype wire
